>>> src/lzss_window_decompressor_macros.svh
// ---------------------------------------------------------------------------
// lzss window decompressor assertion macros
// concurrent property checks, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LZSSWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LZSSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LZSSWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LZSSWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/lzsswd_pkg.sv
// ---------------------------------------------------------------------------
// lzsswd_pkg
// shared constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package lzsswd_pkg;

  localparam int unsigned WINDOW_DEPTH    = 4096;
  localparam int unsigned ADDR_W          = $clog2(WINDOW_DEPTH);
  localparam int unsigned BLEN_W          = 25;
  localparam int unsigned MAX_BLOCK_BYTES = 16777216;
  localparam int unsigned BLOCK_LEN_RESET = 16384;
  localparam int unsigned MIN_MATCH       = 3;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned PADDR_W         = 3;

  localparam logic REG_BLOCK_LENGTH = 1'b0;

  typedef struct packed {
    logic clear;
    logic flag;
    logic lit;
    logic low;
    logic pair;
    logic copy;
  } lzsswd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic flag_bit;
    logic out_free;
    logic end_after_lit;
    logic end_now;
    logic copy_done;
  } lzsswd_sts_t;

endpackage

>>> src/lzsswd_ram.sv
// ---------------------------------------------------------------------------
// lzsswd_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module lzsswd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/lzsswd_ctrl.sv
// ---------------------------------------------------------------------------
// lzsswd_ctrl
// token sequencing state machine: history clear, flag, literal, pair, copy
// ---------------------------------------------------------------------------
module lzsswd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lzsswd_pkg::lzsswd_sts_t  sts_i,
  output lzsswd_pkg::lzsswd_cmd_t  cmd_o
);
  import lzsswd_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FLAG,
    ST_TOKEN,
    ST_PAIR,
    ST_COPY
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_FLAG;
        end
      end
      ST_FLAG: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.flag = 1'b1;
          state_d    = ST_TOKEN;
        end
      end
      ST_TOKEN: begin
        if (sts_i.flag_bit) begin
          in_ready_o = sts_i.out_free;
          if (acc) begin
            cmd_o.lit = 1'b1;
            state_d   = sts_i.end_after_lit ? ST_FLAG : ST_TOKEN;
          end
        end else begin
          in_ready_o = 1'b1;
          if (acc) begin
            cmd_o.low = 1'b1;
            state_d   = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        in_ready_o = 1'b1;
        if (acc) begin
          cmd_o.pair = 1'b1;
          state_d    = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        if (sts_i.copy_done) begin
          state_d = sts_i.end_now ? ST_FLAG : ST_TOKEN;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/lzsswd_datapath.sv
// ---------------------------------------------------------------------------
// lzsswd_datapath
// history ram, token registers, copy read pipeline and output register
// ---------------------------------------------------------------------------
module lzsswd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lzsswd_pkg::lzsswd_cmd_t             cmd_i,
  output lzsswd_pkg::lzsswd_sts_t             sts_o,
  input  logic [7:0]                          in_byte_i,
  input  logic [lzsswd_pkg::BLEN_W-1:0]       block_length_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          out_byte_o,
  output logic                                run_last_o,
  output logic                                block_last_o
);
  import lzsswd_pkg::*;

  localparam logic [BLEN_W-1:0] MaxLen = BLEN_W'(MAX_BLOCK_BYTES);

  logic [ADDR_W-1:0] clr_q, wp_q, src_q;
  logic [8:0]        shift_q;
  logic [7:0]        low_q;
  logic [BLEN_W-1:0] rem_q;
  logic [LEN_W-1:0]  cnt_q;
  logic              rd_valid_q, rd_last_q, fwd_q;
  logic [7:0]        fwd_byte_q;
  logic              out_valid_q, out_run_q, out_blk_q;
  logic [7:0]        out_byte_q;

  logic              out_free, copy_load, issue, ram_we;
  logic [7:0]        ram_rdata, copy_byte, ram_wdata;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BLEN_W-1:0] load_len;
  logic [LEN_W-1:0]  match_len, eff_len;

  assign out_free  = !out_valid_q || out_ready_i;
  assign copy_byte = fwd_q ? fwd_byte_q : ram_rdata;
  assign copy_load = cmd_i.copy && rd_valid_q && out_free;
  assign issue     = cmd_i.copy && (cnt_q != '0) && (!rd_valid_q || copy_load);

  always_comb begin
    if (block_length_i == '0) begin
      load_len = BLEN_W'(1);
    end else if (block_length_i > MaxLen) begin
      load_len = MaxLen;
    end else begin
      load_len = block_length_i;
    end
    match_len = LEN_W'(in_byte_i[7:4]) + LEN_W'(MIN_MATCH);
    eff_len   = (BLEN_W'(match_len) > rem_q) ? LEN_W'(rem_q) : match_len;
  end

  assign ram_we    = cmd_i.clear || cmd_i.lit || copy_load;
  assign ram_waddr = cmd_i.clear ? clr_q : wp_q;
  assign ram_wdata = cmd_i.clear ? 8'h00 : (cmd_i.lit ? in_byte_i : copy_byte);

  lzsswd_ram #(
    .Width (8),
    .Depth (WINDOW_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (src_q),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      wp_q        <= '0;
      shift_q     <= 9'd1;
      rem_q       <= '0;
      cnt_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.lit || copy_load) begin
        wp_q <= wp_q + 1'b1;
      end
      if (cmd_i.flag) begin
        shift_q <= {1'b1, in_byte_i};
        if (rem_q == '0) begin
          rem_q <= load_len;
        end
      end
      if (cmd_i.lit) begin
        shift_q <= shift_q >> 1;
        rem_q   <= rem_q - 1'b1;
      end
      if (cmd_i.pair) begin
        shift_q <= shift_q >> 1;
        rem_q   <= rem_q - BLEN_W'(eff_len);
        cnt_q   <= eff_len;
      end
      if (issue) begin
        cnt_q      <= cnt_q - 1'b1;
        rd_valid_q <= 1'b1;
      end else if (copy_load) begin
        rd_valid_q <= 1'b0;
      end
      if (cmd_i.lit || copy_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.low) begin
      low_q <= in_byte_i;
    end
    if (cmd_i.pair) begin
      src_q <= wp_q + {in_byte_i[3:0], low_q};
    end else if (issue) begin
      src_q <= src_q + 1'b1;
    end
    if (issue) begin
      rd_last_q  <= (cnt_q == LEN_W'(1));
      // read of the address being written this cycle takes the new byte
      fwd_q      <= copy_load && (src_q == wp_q);
      fwd_byte_q <= copy_byte;
    end
    if (cmd_i.lit) begin
      out_byte_q <= in_byte_i;
      out_run_q  <= 1'b1;
      out_blk_q  <= (rem_q == BLEN_W'(1));
    end else if (copy_load) begin
      out_byte_q <= copy_byte;
      out_run_q  <= rd_last_q;
      out_blk_q  <= rd_last_q && (rem_q == '0);
    end
  end

  assign sts_o.clear_last    = &clr_q;
  assign sts_o.flag_bit      = shift_q[0];
  assign sts_o.out_free      = out_free;
  assign sts_o.end_after_lit = (rem_q == BLEN_W'(1)) || (shift_q[8:2] == '0);
  assign sts_o.end_now       = (rem_q == '0) || (shift_q[8:1] == '0);
  assign sts_o.copy_done     = (cnt_q == '0) && !rd_valid_q;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = out_run_q;
  assign block_last_o = out_blk_q;

endmodule

>>> src/lzss_window_decompressor.sv
// ---------------------------------------------------------------------------
// lzss_window_decompressor
// lzss decoder with a 4096-byte history window and programmable block length
// ---------------------------------------------------------------------------
// After reset the history ram is cleared, one entry a cycle, before the first
// compressed byte is accepted; register writes are taken throughout. Flag
// bytes and the low byte of a match pair are accepted one per cycle, literals
// only while the output register can take the result. A match holds the
// input while it is copied: a first step starts the read on the history ram's
// read port, then one decompressed byte leaves per cycle, and a last step
// hands back to token sequencing. Output back-pressure stalls the copy
// without losing bytes.
// ---------------------------------------------------------------------------
`include "lzss_window_decompressor_macros.svh"

module lzss_window_decompressor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            run_last_o,
  output logic                            block_last_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lzsswd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import lzsswd_pkg::*;

  lzsswd_cmd_t       cmd;
  lzsswd_sts_t       sts;
  logic [BLEN_W-1:0] block_length_q;
  logic              reg_hit;

  assign reg_hit = (paddr[PADDR_W-1] == REG_BLOCK_LENGTH);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(block_length_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= BLEN_W'(BLOCK_LEN_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      block_length_q <= pwdata[BLEN_W-1:0];
    end
  end

  lzsswd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lzsswd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (in_byte_i),
    .block_length_i (block_length_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .block_last_o   (block_last_o)
  );

  `LZSSWD_ASSERT_IMPL(a_no_input_in_clear, clk_i, rst_ni, cmd.clear, !in_ready_o, "input taken during history clear")
  `LZSSWD_ASSERT_IMPL(a_no_input_in_copy, clk_i, rst_ni, cmd.copy, !in_ready_o, "input taken during match copy")
  `LZSSWD_ASSERT_NEXT(a_pair_starts_copy, clk_i, rst_ni, cmd.pair, cmd.copy, "match pair did not start a copy")
  `LZSSWD_ASSERT_IMPL(a_block_end_is_run_end, clk_i, rst_ni, out_valid_o && block_last_o, run_last_o, "block end without run end")

endmodule

>>> tb/tb_lzss_window_decompressor.sv
// ---------------------------------------------------------------------------
// tb_lzss_window_decompressor
// self-checking bench: directed token table, then random compressed streams
// in three phases with different handshake idling, checked beat by beat
// against a behavioural decoder that tracks the window and block state
// ---------------------------------------------------------------------------
module tb_lzss_window_decompressor;
  import lzsswd_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 32;
  localparam int HOLD_CYCLES     = 300;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int MAX_REPORTS     = 10;
  localparam int N_DIRECTED      = 26;

  localparam logic [PADDR_W-1:0] ADDR_BLOCK_LENGTH = PADDR_W'(4 * int'(REG_BLOCK_LENGTH));
  localparam logic [PADDR_W-1:0] ADDR_UNUSED       = PADDR_W'(4);
  localparam logic [31:0]        BLEN_ALL_ONES     = 32'(2 ** BLEN_W - 1);

  typedef enum logic [1:0] {TS_FLAG, TS_TOKEN, TS_PAIR_HIGH} token_state_e;
  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       block_last;
  } out_beat_t;

  typedef struct packed {
    row_kind_e          kind;
    logic [PADDR_W-1:0] addr;
    logic [31:0]        value;
    logic               typed;
    out_beat_t          beat;
  } stim_row_t;

  // write rows carry a register value, byte rows the compressed byte in value
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WRITE, ADDR_BLOCK_LENGTH, 32'd0,  1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0000, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_BYTE,  '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ROW_WRITE, ADDR_BLOCK_LENGTH, 32'd1,  1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0001, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0080, 1'b1, '{8'h80, 1'b1, 1'b1}},
    '{ROW_WRITE, ADDR_BLOCK_LENGTH, 32'd20, 1'b0, '0},
    '{ROW_WRITE, ADDR_UNUSED,       32'd3,  1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00fe, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00a5, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_005a, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0001, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0080, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_007f, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00c3, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00fe, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_000f, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b0, '0},
    '{ROW_BYTE,  '0, 32'h0000_00ff, 1'b0, '0}
  };

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic [7:0]         in_byte_i    = 8'h00;
  logic               out_ready_i  = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [7:0]         out_byte_o;
  logic               run_last_o;
  logic               block_last_o;
  logic [31:0]        prdata;
  logic               pready;

  // decoder state mirror
  logic [7:0]         hist [WINDOW_DEPTH] = '{default: 8'h00};
  logic [ADDR_W-1:0]  wr_ptr    = '0;
  logic [8:0]         flag_bits = 9'h001;
  token_state_e       tok_state = TS_FLAG;
  logic [7:0]         pair_lo   = 8'h00;
  logic [BLEN_W-1:0]  remaining = '0;
  logic [BLEN_W-1:0]  blen_reg  = BLEN_W'(BLOCK_LEN_RESET);
  out_beat_t          pending_bytes [$];

  int err_cnt       = 0;
  int cycle_cnt     = 0;
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_req_cnt  = 0;
  int hold_ack_cnt  = 0;
  int hold_left     = 0;
  bit pair_near     = 1'b0;

  lzss_window_decompressor uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .block_last_o(block_last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic void next_token_state();
    flag_bits = flag_bits >> 1;
    if (remaining == 0 || flag_bits <= 9'h001) begin
      flag_bits = 9'h001;
      tok_state = TS_FLAG;
    end else begin
      tok_state = TS_TOKEN;
    end
  endfunction

  // decodes one compressed byte and queues the bytes it releases
  function automatic void decode_byte(input logic [7:0] b, output int n_out);
    logic [15:0]       pair;
    logic [ADDR_W-1:0] src;
    int unsigned       run_len;
    out_beat_t         beat;
    n_out = 0;
    case (tok_state)
      TS_FLAG: begin
        if (remaining == 0) begin
          if (blen_reg == 0) remaining = BLEN_W'(1);
          else if (blen_reg > MAX_BLOCK_BYTES) remaining = BLEN_W'(MAX_BLOCK_BYTES);
          else remaining = blen_reg;
        end
        flag_bits = {1'b1, b};
        tok_state = TS_TOKEN;
      end
      TS_TOKEN: begin
        if (flag_bits[0]) begin
          hist[wr_ptr] = b;
          wr_ptr++;
          remaining--;
          beat = '{b, 1'b1, remaining == 0};
          pending_bytes.push_back(beat);
          n_out = 1;
          next_token_state();
        end else begin
          pair_lo = b;
          tok_state = TS_PAIR_HIGH;
        end
      end
      default: begin
        pair = {b, pair_lo};
        src = wr_ptr + pair[ADDR_W-1:0];
        run_len = pair[15:12] + MIN_MATCH;
        if (run_len > 32'(remaining)) run_len = 32'(remaining);
        remaining -= BLEN_W'(run_len);
        for (int k = 0; k < run_len; k++) begin
          beat.data = hist[src];
          hist[wr_ptr] = hist[src];
          wr_ptr++;
          src++;
          beat.run_last = (k == run_len - 1);
          beat.block_last = beat.run_last && remaining == 0;
          pending_bytes.push_back(beat);
          n_out++;
        end
        next_token_state();
      end
    endcase
  endfunction

  // entered and left at a falling edge; valid is left high for the caller
  task automatic send_byte(input logic [7:0] b, output int n_out);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, n_out);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_BLOCK_LENGTH) blen_reg = value[BLEN_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] blen, input int snd_pct, input int rcv_pct,
                           input int pause_at, input int hold_at);
    logic [7:0] b;
    int n;
    wait_drained();
    apb_write(ADDR_BLOCK_LENGTH, blen);
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (i == pause_at) wait_drained();
      if (i == hold_at) hold_req_cnt++;
      case (tok_state)
        TS_FLAG: b = 8'($urandom_range(255));
        TS_TOKEN: begin
          if (flag_bits[0]) begin
            b = 8'($urandom_range(255));
          end else begin
            // mostly short distances so copies reuse recent output
            pair_near = ($urandom_range(3) != 0);
            b = pair_near ? 8'($urandom_range(255, 192)) : 8'($urandom_range(255));
          end
        end
        default: b = pair_near ? {4'($urandom_range(15)), 4'hf} : 8'($urandom_range(255));
      endcase
      send_byte(b, n);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      out_ready_i <= 1'b0;
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        note_mismatch("transaction with nothing pending", '0, out_byte_o);
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte_o !== want.data) note_mismatch("out_byte", want.data, out_byte_o);
        if (run_last_o !== want.run_last) note_mismatch("run_last", want.run_last, run_last_o);
        if (block_last_o !== want.block_last) begin
          note_mismatch("block_last", want.block_last, block_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("lzss_window_decompressor verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    logic [31:0] rd;
    snd_idle_pct = 8;
    rcv_stall_pct = 53;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value readback
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= ADDR_BLOCK_LENGTH;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (rd !== BLOCK_LEN_RESET) note_mismatch("block_length after reset", BLOCK_LEN_RESET, rd);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        wait_drained();
        apb_write(DIRECTED[r].addr, DIRECTED[r].value);
      end else begin
        send_byte(DIRECTED[r].value[7:0], n);
        if (DIRECTED[r].typed) begin
          if (n != 1) note_mismatch("bytes released", 1, n);
          else pending_bytes[pending_bytes.size() - 1] = DIRECTED[r].beat;
        end
      end
    end

    run_phase($urandom_range(64, 8), 8, 53, 30, -1);
    run_phase($urandom_range(24, 1), 53, 8, -1, -1);
    run_phase(BLEN_ALL_ONES, 0, 0, -1, 10);
    wait_drained();

    if (err_cnt == 0) begin
      $display("lzss_window_decompressor verification clean");
    end else begin
      $display("lzss_window_decompressor verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/lzsswd_pkg.sv
src/lzsswd_ram.sv
src/lzsswd_ctrl.sv
src/lzsswd_datapath.sv
src/lzss_window_decompressor.sv
tb/tb_lzss_window_decompressor.sv
